// File: rtl/core/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the binary-lifting lowest common ancestor unit.
// ----------------------------------------------------------------------------
package lca_pkg;

	localparam int NODE_W     = 10;
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 10;

	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_QUERY  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		CMP_LT,
		CMP_GE,
		CMP_EQ,
		CMP_NE
	} cmp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS,
		S_QDEP,
		S_QORD,
		S_QPRE,
		S_QUP,
		S_QCHK,
		S_QLIFT,
		S_QFIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic lift_we;
		logic depth_we;
	} tbl_wr_t;

endpackage

// File: rtl/core/lca_if.sv
// ----------------------------------------------------------------------------
// lca_if
// Valid/ready channels for requests into and answers out of the LCA unit.
// ----------------------------------------------------------------------------
interface lca_req_if import lca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, func, node_a, node_b, input ready);
	modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

interface lca_rsp_if import lca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] ancestor;

	modport source (output valid, ancestor, input ready);
	modport sink   (input valid, ancestor, output ready);
endinterface

// File: rtl/core/lca_cmp.sv
// ----------------------------------------------------------------------------
// lca_cmp
// Shared unsigned comparator used by the sequencer's insert and query walks.
// ----------------------------------------------------------------------------
module lca_cmp import lca_pkg::*; #(
	parameter int W = NODE_W
) (
	input  cmp_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         res
);

	always_comb begin
		unique case (op)
			CMP_LT:  res = (a < b);
			CMP_GE:  res = (a >= b);
			CMP_EQ:  res = (a == b);
			CMP_NE:  res = (a != b);
			default: res = 1'b0;
		endcase
	end

endmodule

// File: rtl/core/lca_tables.sv
// ----------------------------------------------------------------------------
// lca_tables
// Ancestor table and depth table with two registered read ports each.
// ----------------------------------------------------------------------------
module lca_tables import lca_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                       clk,
	input  tbl_wr_t                    wr,
	input  logic [NODE_W-1:0]          wr_node,
	input  logic [$clog2(LEVELS)-1:0]  lift_wr_lvl,
	input  logic [NODE_W-1:0]          lift_wr_data,
	input  logic [$clog2(NODES)-1:0]   depth_wr_data,
	input  logic [NODE_W-1:0]          lift_ra_node,
	input  logic [$clog2(LEVELS)-1:0]  lift_ra_lvl,
	input  logic [NODE_W-1:0]          lift_rb_node,
	input  logic [$clog2(LEVELS)-1:0]  lift_rb_lvl,
	input  logic [NODE_W-1:0]          depth_ra_node,
	input  logic [NODE_W-1:0]          depth_rb_node,
	output logic [NODE_W-1:0]          lift_ra_data,
	output logic [NODE_W-1:0]          lift_rb_data,
	output logic [$clog2(NODES)-1:0]   depth_ra_data,
	output logic [$clog2(NODES)-1:0]   depth_rb_data
);

	localparam int AW = $clog2(NODES);
	localparam int DW = $clog2(NODES);

	logic [NODE_W-1:0] lift_mem  [NODES][LEVELS];
	logic [DW-1:0]     depth_mem [NODES];

	logic [NODE_W-1:0] lift_ra_q, lift_rb_q;
	logic [DW-1:0]     depth_ra_q, depth_rb_q;
	logic              lift_ra_zero_q, lift_rb_zero_q;
	logic              depth_ra_zero_q, depth_rb_zero_q;

	// Node 0 is never written; its row and depth read as zero through the
	// address flags, so the memories need no clearing after reset.
	always_ff @(posedge clk) begin
		if (wr.lift_we) begin
			lift_mem[AW'(wr_node)][lift_wr_lvl] <= lift_wr_data;
		end
		if (wr.depth_we) begin
			depth_mem[AW'(wr_node)] <= depth_wr_data;
		end
		lift_ra_q       <= lift_mem[AW'(lift_ra_node)][lift_ra_lvl];
		lift_rb_q       <= lift_mem[AW'(lift_rb_node)][lift_rb_lvl];
		depth_ra_q      <= depth_mem[AW'(depth_ra_node)];
		depth_rb_q      <= depth_mem[AW'(depth_rb_node)];
		lift_ra_zero_q  <= (lift_ra_node == '0);
		lift_rb_zero_q  <= (lift_rb_node == '0);
		depth_ra_zero_q <= (depth_ra_node == '0);
		depth_rb_zero_q <= (depth_rb_node == '0);
	end

	assign lift_ra_data  = lift_ra_zero_q  ? '0 : lift_ra_q;
	assign lift_rb_data  = lift_rb_zero_q  ? '0 : lift_rb_q;
	assign depth_ra_data = depth_ra_zero_q ? '0 : depth_ra_q;
	assign depth_rb_data = depth_rb_zero_q ? '0 : depth_rb_q;

endmodule

// File: rtl/core/lca_seq.sv
// ----------------------------------------------------------------------------
// lca_seq
// Sequencer for inserts and queries: walks the tables one level per cycle
// and drives the shared comparator and the answer register.
// ----------------------------------------------------------------------------
module lca_seq import lca_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lca_req_if.sink                    req,
	lca_rsp_if.source                  rsp,
	output tbl_wr_t                    wr,
	output logic [NODE_W-1:0]          wr_node,
	output logic [$clog2(LEVELS)-1:0]  lift_wr_lvl,
	output logic [NODE_W-1:0]          lift_wr_data,
	output logic [$clog2(NODES)-1:0]   depth_wr_data,
	output logic [NODE_W-1:0]          lift_ra_node,
	output logic [$clog2(LEVELS)-1:0]  lift_ra_lvl,
	output logic [NODE_W-1:0]          lift_rb_node,
	output logic [$clog2(LEVELS)-1:0]  lift_rb_lvl,
	output logic [NODE_W-1:0]          depth_ra_node,
	output logic [NODE_W-1:0]          depth_rb_node,
	input  logic [NODE_W-1:0]          lift_ra_data,
	input  logic [NODE_W-1:0]          lift_rb_data,
	input  logic [$clog2(NODES)-1:0]   depth_ra_data,
	input  logic [$clog2(NODES)-1:0]   depth_rb_data
);

	localparam int LW = $clog2(LEVELS);
	localparam int DW = $clog2(NODES);
	localparam int CW = (DW > NODE_W) ? DW : NODE_W;
	localparam logic [LW-1:0] LTOP = LW'(LEVELS - 1);

	state_t            state_q, state_d;
	logic [LW-1:0]     k_q;
	logic [NODE_W-1:0] x_q, y_q, up_q, res_q;
	logic [DW-1:0]     dx_q;
	logic              rsp_valid_q;
	logic [NODE_W-1:0] rsp_anc_q;

	cmp_op_t           cmp_op;
	logic [CW-1:0]     cmp_a, cmp_b;
	logic              cmp_res;

	logic              accept, slot_free, bad_a, bad_b;
	logic [LW-1:0]     lvl_dec, lvl_dec2;
	logic [NODE_W-1:0] ins_cur, ydeep, ynew, up_next, xn, yn;
	logic [DW-1:0]     dep_inc;

	lca_cmp #(.W(CW)) u_cmp (
		.op  (cmp_op),
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign bad_a     = (32'(req.node_a) >= NODES) || (req.node_a == '0);
	assign bad_b     = (32'(req.node_b) >= NODES);
	assign lvl_dec   = (k_q == '0) ? '0 : k_q - LW'(1);
	assign lvl_dec2  = (32'(k_q) < 2) ? '0 : k_q - LW'(2);

	// Comparator operand selection.
	always_comb begin
		cmp_op = CMP_EQ;
		cmp_a  = '0;
		cmp_b  = '0;
		unique case (state_q)
			S_INS: begin
				cmp_op = CMP_LT;
				cmp_a  = CW'(depth_ra_data);
				cmp_b  = CW'(NODES - 1);
			end
			S_QORD: begin
				// Swap when the first node is the deeper one.
				cmp_op = CMP_LT;
				cmp_a  = CW'(depth_rb_data);
				cmp_b  = CW'(depth_ra_data);
			end
			S_QUP: begin
				cmp_op = CMP_GE;
				cmp_a  = CW'(depth_ra_data);
				cmp_b  = CW'(dx_q);
			end
			S_QCHK: begin
				cmp_op = CMP_EQ;
				cmp_a  = CW'(x_q);
				cmp_b  = CW'(y_q);
			end
			S_QLIFT: begin
				cmp_op = CMP_NE;
				cmp_a  = CW'(lift_ra_data);
				cmp_b  = CW'(lift_rb_data);
			end
			default: begin
				cmp_op = CMP_EQ;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.func == FN_INSERT) begin
						state_d = (bad_a || bad_b) ? S_IDLE : S_INS;
					end else begin
						state_d = (bad_a || bad_b || req.node_b == '0) ? S_DONE : S_QDEP;
					end
				end
			end
			S_INS:   state_d = (k_q == LTOP) ? S_IDLE : S_INS;
			S_QDEP:  state_d = S_QORD;
			S_QORD:  state_d = S_QPRE;
			S_QPRE:  state_d = S_QUP;
			S_QUP:   state_d = (k_q == '0) ? S_QCHK : S_QUP;
			S_QCHK:  state_d = cmp_res ? S_DONE : S_QLIFT;
			S_QLIFT: state_d = (k_q == '0) ? S_QFIN : S_QLIFT;
			S_QFIN:  state_d = S_DONE;
			S_DONE:  state_d = slot_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// Table ports and per-step datapath values.
	always_comb begin
		req.ready     = 1'b0;
		wr            = '0;
		wr_node       = x_q;
		lift_wr_lvl   = k_q;
		ins_cur       = (k_q == '0) ? y_q : lift_ra_data;
		lift_wr_data  = ins_cur;
		dep_inc       = cmp_res ? depth_ra_data + DW'(1) : depth_ra_data;
		depth_wr_data = dep_inc;
		lift_ra_node  = '0;
		lift_ra_lvl   = '0;
		lift_rb_node  = '0;
		lift_rb_lvl   = '0;
		depth_ra_node = '0;
		depth_rb_node = '0;
		ydeep         = cmp_res ? x_q : y_q;
		ynew          = cmp_res ? up_q : y_q;
		up_next       = cmp_res ? lift_ra_data : lift_rb_data;
		xn            = cmp_res ? lift_ra_data : x_q;
		yn            = cmp_res ? lift_rb_data : y_q;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_INS: begin
				// Entry k of the new row is written while the row it names is
				// read at level k, which yields entry k+1 in the next cycle.
				wr.lift_we    = 1'b1;
				wr.depth_we   = (k_q == LW'(1));
				lift_ra_node  = ins_cur;
				lift_ra_lvl   = k_q;
				depth_ra_node = y_q;
			end
			S_QDEP: begin
				depth_ra_node = x_q;
				depth_rb_node = y_q;
			end
			S_QORD: begin
				lift_ra_node = ydeep;
				lift_ra_lvl  = LTOP;
			end
			S_QPRE: begin
				depth_ra_node = lift_ra_data;
				lift_ra_node  = lift_ra_data;
				lift_ra_lvl   = lvl_dec;
				lift_rb_node  = y_q;
				lift_rb_lvl   = lvl_dec;
			end
			S_QUP: begin
				// Both outcomes of this level's jump are fetched ahead, so the
				// depth test of one level overlaps the reads of the next.
				depth_ra_node = up_next;
				lift_ra_node  = up_next;
				lift_ra_lvl   = lvl_dec2;
				lift_rb_node  = ynew;
				lift_rb_lvl   = lvl_dec2;
			end
			S_QCHK: begin
				lift_ra_node = x_q;
				lift_ra_lvl  = LTOP;
				lift_rb_node = y_q;
				lift_rb_lvl  = LTOP;
			end
			S_QLIFT: begin
				lift_ra_node = xn;
				lift_ra_lvl  = lvl_dec;
				lift_rb_node = yn;
				lift_rb_lvl  = lvl_dec;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  k_q <= '0;
				S_INS:   k_q <= (k_q == LTOP) ? '0 : k_q + LW'(1);
				S_QORD:  k_q <= LTOP;
				S_QCHK:  k_q <= LTOP;
				S_QUP:   k_q <= lvl_dec;
				S_QLIFT: k_q <= lvl_dec;
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			rsp_anc_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q   <= req.node_a;
					y_q   <= req.node_b;
					res_q <= '0;
				end
			end
			S_QORD: begin
				if (cmp_res) begin
					x_q <= y_q;
					y_q <= x_q;
				end
				dx_q <= cmp_res ? depth_rb_data : depth_ra_data;
			end
			S_QPRE: begin
				up_q <= lift_ra_data;
			end
			S_QUP: begin
				y_q  <= ynew;
				up_q <= up_next;
			end
			S_QCHK: begin
				res_q <= x_q;
			end
			S_QLIFT: begin
				x_q <= xn;
				y_q <= yn;
			end
			S_QFIN: begin
				res_q <= lift_ra_data;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.ancestor = rsp_anc_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(k_q) < LEVELS)
		else $error("level counter beyond the table depth");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QFIN |=> state_q == S_DONE)
		else $error("final read not followed by the answer step");

	a_chk_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QCHK |=> state_q == S_DONE || (state_q == S_QLIFT && k_q == LTOP))
		else $error("common lift did not start from the top level");

	a_answer_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && slot_free |=> rsp.valid && rsp.ancestor == $past(res_q))
		else $error("answer register not loaded from the result");

endmodule

// File: rtl/core/lca_binary_lifting_unit.sv
// Insert: accepted in S_IDLE, then a table walk in S_INS writes the new row level by level.
// Query: lifts the deeper node to the other's depth, then both nodes unless one is an
// ancestor of the other, one dependent table read per level, then loads the answer.
// Queries on node 0 or out-of-range nodes skip the walk and load a zero answer.
// One transaction at a time; a new one is taken while the answer still waits.
// Reset clears control only; node 0 reads as zero by address, no clearing pass.
// ----------------------------------------------------------------------------
// lca_binary_lifting_unit
// Lowest common ancestor over a tree built by parent-first insertion, using a
// binary-lifting ancestor table and a depth table.
// ----------------------------------------------------------------------------
module lca_binary_lifting_unit import lca_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lca_req_if.sink    req,
	lca_rsp_if.source  rsp
);

	localparam int LW = $clog2(LEVELS);
	localparam int DW = $clog2(NODES);

	tbl_wr_t           wr;
	logic [NODE_W-1:0] wr_node, lift_wr_data;
	logic [LW-1:0]     lift_wr_lvl, lift_ra_lvl, lift_rb_lvl;
	logic [DW-1:0]     depth_wr_data, depth_ra_data, depth_rb_data;
	logic [NODE_W-1:0] lift_ra_node, lift_rb_node, depth_ra_node, depth_rb_node;
	logic [NODE_W-1:0] lift_ra_data, lift_rb_data;

	lca_seq #(.NODES(NODES), .LEVELS(LEVELS)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.wr            (wr),
		.wr_node       (wr_node),
		.lift_wr_lvl   (lift_wr_lvl),
		.lift_wr_data  (lift_wr_data),
		.depth_wr_data (depth_wr_data),
		.lift_ra_node  (lift_ra_node),
		.lift_ra_lvl   (lift_ra_lvl),
		.lift_rb_node  (lift_rb_node),
		.lift_rb_lvl   (lift_rb_lvl),
		.depth_ra_node (depth_ra_node),
		.depth_rb_node (depth_rb_node),
		.lift_ra_data  (lift_ra_data),
		.lift_rb_data  (lift_rb_data),
		.depth_ra_data (depth_ra_data),
		.depth_rb_data (depth_rb_data)
	);

	lca_tables #(.NODES(NODES), .LEVELS(LEVELS)) u_tables (
		.clk           (clk),
		.wr            (wr),
		.wr_node       (wr_node),
		.lift_wr_lvl   (lift_wr_lvl),
		.lift_wr_data  (lift_wr_data),
		.depth_wr_data (depth_wr_data),
		.lift_ra_node  (lift_ra_node),
		.lift_ra_lvl   (lift_ra_lvl),
		.lift_rb_node  (lift_rb_node),
		.lift_rb_lvl   (lift_rb_lvl),
		.depth_ra_node (depth_ra_node),
		.depth_rb_node (depth_rb_node),
		.lift_ra_data  (lift_ra_data),
		.lift_rb_data  (lift_rb_data),
		.depth_ra_data (depth_ra_data),
		.depth_rb_data (depth_rb_data)
	);

endmodule
